### hw/rtl/brf_pkg.sv
`default_nettype none

package brf_pkg;

    // Default depth of the byte store.
    localparam int DEF_STORE_DEPTH = 256;

    // Field widths of the request, the result and the ring-size register.
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 9;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 8;
    localparam int CFG_W   = 9;

    // Width of the pointer arithmetic. The ring never exceeds 511 bytes, so
    // a pointer plus a count always stays below 2048.
    localparam int CALC_W  = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 3'd2;
    localparam logic [OP_W-1:0] OP_ROOM    = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOROOM = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture the request fields
        logic exec;       // perform the operation and load the result
        logic load_byte;  // take the store read data into the result
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic read_hit;   // the captured request is a read of a non-empty ring
    } t_dp_status;

endpackage

`default_nettype wire

### hw/rtl/brf_ram.sv
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/brf_ctrl.sv
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd,
    output logic            busy,
    output logic            o_result_valid
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_RDDATA = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.read_hit) begin
                    n_state = S_RDDATA;
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            S_RDDATA: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_result_valid    = r_valid;
    assign o_cmd.accept      = start && (r_state == S_IDLE);
    assign o_cmd.exec        = (r_state == S_EXEC);
    assign o_cmd.load_byte   = (r_state == S_RDDATA);

    // Every request passes through the execute state before its strobe, so strobes never touch.
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe high in two consecutive cycles");

    // An accepted request is executed in the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // The read data cycle always ends with a result.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDDATA) |=> r_valid)
        else $error("read finished without a result strobe");

endmodule

`default_nettype wire

### hw/rtl/brf_datapath.sv
`default_nettype none

module brf_datapath
    import brf_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl_cmd          i_cmd,
    output t_dp_status             o_status,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [BYTE_W-1:0] i_write_byte,
    input  wire logic [CNT_W-1:0]  i_amount,
    output logic      [BYTE_W-1:0] o_read_byte,
    output logic      [STAT_W-1:0] o_status_code,
    output logic                   o_now_empty,
    output logic      [CNT_W-1:0]  o_byte_count,
    output logic      [POS_W-1:0]  o_read_position
);

    localparam int PTR_W = $clog2(STORE_DEPTH);

    // Pointer advance with a single wrap.
    function automatic logic [CALC_W-1:0] adv(
        input logic [CALC_W-1:0] p,
        input logic [CALC_W-1:0] n,
        input logic [CALC_W-1:0] sz
    );
        logic [CALC_W-1:0] s;
        s = p + n;
        if (s >= sz) begin
            s = s - sz;
        end
        return s;
    endfunction

    // Control state.
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic             r_full, n_full;
    logic [CFG_W-1:0] r_size;

    // Captured request.
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_wbyte;
    logic [CNT_W-1:0]  r_amount;

    // Result registers.
    logic [BYTE_W-1:0] r_read_byte;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_now_empty, n_now_empty;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_rpos, n_rpos;

    logic [CALC_W-1:0] sz, rp, wp, amt, stored, room, cnt, step_rp, step_wp;
    logic              empty, read_hit, ram_we;
    logic [PTR_W-1:0]  ram_addr;
    logic [BYTE_W-1:0] ram_rdata;

    always_comb begin
        if (r_size == '0) begin
            sz = CALC_W'(1);
        end else if (32'(r_size) > STORE_DEPTH) begin
            sz = CALC_W'(STORE_DEPTH);
        end else begin
            sz = CALC_W'(r_size);
        end
    end

    assign rp     = CALC_W'(r_rp);
    assign wp     = CALC_W'(r_wp);
    assign amt    = CALC_W'(r_amount);
    assign empty  = (r_rp == r_wp) && !r_full;
    assign stored = r_full ? sz : ((wp >= rp) ? (wp - rp) : (wp + sz - rp));
    assign room   = sz - stored;
    assign cnt    = (amt < stored) ? amt : stored;

    assign step_wp = adv(wp, CALC_W'(1), sz);
    assign step_rp = (r_op == OP_READ) ? adv(rp, CALC_W'(1), sz) : adv(rp, cnt, sz);

    assign read_hit = (r_op == OP_READ) && !empty;
    assign ram_we   = i_cmd.exec && (r_op == OP_WRITE) && !r_full;
    assign ram_addr = (r_op == OP_WRITE) ? r_wp : r_rp;

    always_comb begin
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_full      = r_full;
        n_status    = ST_OK;
        n_now_empty = 1'b0;
        n_count     = '0;
        n_rpos      = '0;
        case (r_op)
            OP_WRITE: begin
                if (r_full) begin
                    n_status = ST_NOROOM;
                end else begin
                    n_wp   = PTR_W'(step_wp);
                    n_full = (step_wp == rp);
                end
            end
            OP_READ: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rp        = PTR_W'(step_rp);
                    n_full      = 1'b0;
                    n_now_empty = (step_rp == wp);
                end
            end
            OP_DISCARD: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (amt != '0) begin
                    n_rp    = PTR_W'(step_rp);
                    n_full  = 1'b0;
                    n_count = CNT_W'(cnt);
                end
            end
            OP_ROOM: begin
                if (r_full || (amt > room)) begin
                    n_status = ST_NOROOM;
                end
            end
            OP_QUERY: begin
                n_rpos = POS_W'(32'(r_rp));
                if (!empty) begin
                    n_count = CNT_W'((rp >= wp) ? (sz - rp) : (wp - rp));
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_wp   <= '0;
            r_full <= 1'b0;
            r_size <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_rp   <= '0;
            r_wp   <= '0;
            r_full <= 1'b0;
            r_size <= i_cfg_wdata;
        end else if (i_cmd.exec) begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_op;
            r_wbyte  <= i_write_byte;
            r_amount <= i_amount;
        end
        if (i_cmd.exec) begin
            r_read_byte <= '0;
            r_status    <= n_status;
            r_now_empty <= n_now_empty;
            r_count     <= n_count;
            r_rpos      <= n_rpos;
        end else if (i_cmd.load_byte) begin
            r_read_byte <= ram_rdata;
        end
    end

    brf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_wbyte),
        .o_rdata(ram_rdata)
    );

    assign o_status.read_hit = read_hit && i_cmd.exec;
    assign o_read_byte       = r_read_byte;
    assign o_status_code     = r_status;
    assign o_now_empty       = r_now_empty;
    assign o_byte_count      = r_count;
    assign o_read_position   = r_rpos;

    // A full ring has both pointers on the same entry.
    a_full_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_rp == r_wp))
        else $error("full flag set with pointers apart");

    // Both pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rp < sz) && (wp < sz))
        else $error("pointer outside the ring");

endmodule

`default_nettype wire

### hw/rtl/byte_ring_fifo_unit.sv
`default_nettype none

// Byte ring FIFO. A request is taken at a rising edge where start is high and
// busy is low; it carries one of five operations (write, read, discard, room
// check, query of the contiguous readable run) and always produces exactly one
// result, shown on the o_ result ports for a single cycle while o_result_valid
// is high. The receiver cannot stall: the result must be captured in that
// cycle. For a write, discard, room check, query, unknown operation or read
// of an empty ring, the strobe follows the execute state; for a read of a
// non-empty ring it follows the execute and read data states, because the
// byte store is a memory with a registered read port. busy drops in the
// cycle the strobe rises, so the next request can be accepted at the edge
// that ends the strobe cycle; a request is not accepted before the one in
// flight has given its result. The ring size register (i_cfg_we,
// i_cfg_wdata) may only be written while no request is in flight; a write
// also empties the ring, while the store contents are kept. A size of zero
// acts as one and a size above STORE_DEPTH acts as STORE_DEPTH. Reading a
// store entry that was never written returns an undefined byte.

module byte_ring_fifo_unit
    import brf_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Ring size register.
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    // Request side.
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [BYTE_W-1:0] i_write_byte,
    input  wire logic [CNT_W-1:0]  i_amount,
    // Result side.
    output logic                   o_result_valid,
    output logic      [BYTE_W-1:0] o_read_byte,
    output logic      [STAT_W-1:0] o_status,
    output logic                   o_now_empty,
    output logic      [CNT_W-1:0]  o_byte_count,
    output logic      [POS_W-1:0]  o_read_position
);

    t_ctl_cmd   cmd;
    t_dp_status dp_status;

    // The controller sequences each request: capture, execute, and for a read
    // of a non-empty ring a read data step to collect the byte from the store.
    brf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_status      (dp_status),
        .o_cmd         (cmd),
        .busy          (busy),
        .o_result_valid(o_result_valid)
    );

    // The datapath holds the pointers, the full flag, the ring size, the
    // byte store and the result registers.
    brf_datapath #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_op),
        .i_write_byte   (i_write_byte),
        .i_amount       (i_amount),
        .o_read_byte    (o_read_byte),
        .o_status_code  (o_status),
        .o_now_empty    (o_now_empty),
        .o_byte_count   (o_byte_count),
        .o_read_position(o_read_position)
    );

endmodule

`default_nettype wire
